FILE: src/three_plane_track_fit_unit_assert.svh
// Assertion macros for the track fit unit checker.
`ifndef THREE_PLANE_TRACK_FIT_UNIT_ASSERT_SVH
`define THREE_PLANE_TRACK_FIT_UNIT_ASSERT_SVH

// same-cycle implication
`define TPF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tpf_pkg.sv
// Shared types, constants and tables of the track fit unit.
`default_nettype none
package tpf_pkg;
	localparam int NUM_MODULES_DEF       = 3;
	localparam int STRIPS_PER_MODULE_DEF = 32;
	localparam int PLANE_COUNT           = 3;
	localparam int WORD_W                = 32;
	localparam int STRIP_W               = 7;
	localparam int MAX_STRIPS            = 128;
	localparam int RESID_W               = 16;
	localparam int COUNT_W               = 20;
	localparam int CHI_W                 = 23;
	localparam int ANGLE_W               = 15;
	localparam int LUT_W                 = 14;
	localparam int QUEUE_DEPTH           = 2;
	localparam int QPTR_W                = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [RESID_W-1:0] RESID_INIT = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [CHI_W-1:0]   CHI_MAX    = '1;

	// 512*b/3 = 170*b + floor(2*b/3); the third via reciprocal multiply
	localparam int                 CHI_INT_W   = 8;
	localparam logic [CHI_INT_W-1:0] CHI_INT_MUL = 8'd170;
	localparam int                 THIRD_W     = 17;
	localparam logic [THIRD_W-1:0] THIRD_MUL   = 17'd87382;
	localparam int                 THIRD_SHIFT = 18;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef logic [LUT_W-1:0] angle_lut_t [MAX_STRIPS];

	// shift and subtract quotient, only used while the angle table is built
	function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] dvs);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, dvs}) begin
				rem    = rem - {1'b0, dvs};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// round(256 * degrees(atan(a/100))), series evaluated at elaboration
	function automatic angle_lut_t build_angle_lut();
		angle_lut_t  lut;
		logic [63:0] a, a2, den, term, sum, rad, q, deg, n;
		for (int i = 0; i < MAX_STRIPS; i++) begin
			a = 64'(i);
			if (i == 0) begin
				lut[i] = '0;
			end else begin
				a2   = a * a;
				den  = 64'd10000 + a2;
				term = 64'd1 << 40;
				sum  = term;
				for (int k = 1; k <= 120; k++) begin
					n    = 64'(k);
					term = cdiv(term * a2 * (64'd2 * n), den * (64'd2 * n + 64'd1));
					sum  = sum + term;
				end
				rad = cdiv(sum * (64'd100 * a), den);
				q   = cdiv(rad * 64'd46080, 64'd3141592);
				deg = (q * 64'd1000000 + (64'd1 << 39)) >> 40;
				lut[i] = deg[LUT_W-1:0];
			end
		end
		return lut;
	endfunction

	localparam angle_lut_t ANGLE_LUT = build_angle_lut();

	function automatic logic [STRIP_W-1:0] first_set(input logic [MAX_STRIPS-1:0] v);
		logic [STRIP_W-1:0] r;
		r = '0;
		for (int i = MAX_STRIPS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = STRIP_W'(i);
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: src/tpf_front.sv
// Front end: loads hit words into plane bitmaps and hands finished events on.
`default_nettype none
module tpf_front #(
	parameter int NUM_MODULES       = tpf_pkg::NUM_MODULES_DEF,
	parameter int STRIPS_PER_MODULE = tpf_pkg::STRIPS_PER_MODULE_DEF,
	parameter int PLANE_STRIPS      = NUM_MODULES * STRIPS_PER_MODULE
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       in_valid,
	output logic                                            in_stall,
	input  wire logic [1:0]                                 module_index,
	input  wire logic [1:0]                                 plane_index,
	input  wire logic [tpf_pkg::WORD_W-1:0]                 hit_bits,
	input  wire logic                                       end_of_event,
	input  wire tpf_pkg::q_stat_t                           q_stat,
	output logic                                            push,
	output logic [tpf_pkg::PLANE_COUNT*PLANE_STRIPS-1:0]    push_data
);
	import tpf_pkg::*;

	logic [PLANE_COUNT*PLANE_STRIPS-1:0] planes_q;
	logic [PLANE_COUNT*PLANE_STRIPS-1:0] planes_nx;
	logic                                accept;
	logic [1:0]                          plane_m1;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign plane_m1 = plane_index - 2'd1;

	always_comb begin
		planes_nx = planes_q;
		if (plane_index != 2'd0 && 32'(module_index) < 32'(NUM_MODULES)) begin
			planes_nx[32'(plane_m1) * PLANE_STRIPS + 32'(module_index) * STRIPS_PER_MODULE
				+: STRIPS_PER_MODULE] = hit_bits[STRIPS_PER_MODULE-1:0];
		end
	end

	assign push      = accept && end_of_event;
	assign push_data = planes_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (accept) begin
			if (end_of_event) begin
				planes_q <= '0;
			end else begin
				planes_q <= planes_nx;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/tpf_queue.sv
// Short event queue between front end and triple search.
`default_nettype none
module tpf_queue #(
	parameter int DATA_W = 288
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output tpf_pkg::q_stat_t       q_stat
);
	import tpf_pkg::*;

	logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_data     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/tpf_back.sv
// Back end: walks hit triples of one event, ranks them and forms the result.
`default_nettype none
module tpf_back #(
	parameter int PLANE_STRIPS = tpf_pkg::NUM_MODULES_DEF * tpf_pkg::STRIPS_PER_MODULE_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire tpf_pkg::q_stat_t                           q_stat,
	input  wire logic [tpf_pkg::PLANE_COUNT*PLANE_STRIPS-1:0] pop_data,
	output logic                                            pop,
	output logic                                            out_valid,
	input  wire logic                                       out_stall,
	output logic                                            fit_found,
	output logic [tpf_pkg::STRIP_W-1:0]                     best_strip_first,
	output logic [tpf_pkg::STRIP_W-1:0]                     best_strip_second,
	output logic [tpf_pkg::STRIP_W-1:0]                     best_strip_third,
	output logic [tpf_pkg::CHI_W-1:0]                       chi_square_q8,
	output logic [tpf_pkg::COUNT_W-1:0]                     track_count,
	output logic signed [tpf_pkg::ANGLE_W-1:0]              angle_q8
);
	import tpf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHI,
		ST_FIN
	} state_t;

	localparam int PROD_W  = RESID_W + CHI_INT_W;
	localparam int THIRD_P = THIRD_W + THIRD_W;

	state_t                   state_q;
	logic [PLANE_STRIPS-1:0]  rem1_q, rem2_q, rem3_q, full2_q, full3_q;
	logic [PLANE_STRIPS-1:0]  pl1, pl2, pl3;
	logic [PLANE_STRIPS-1:0]  rem1_n, rem2_n, rem3_n;
	logic [MAX_STRIPS-1:0]    w1, w2, w3;
	logic [STRIP_W-1:0]       c1, c2, c3;
	logic signed [STRIP_W+1:0] s;
	logic [STRIP_W:0]         mag;
	logic [RESID_W-1:0]       sq;
	logic [RESID_W-1:0]       best_q;
	logic [STRIP_W-1:0]       b1_q, b2_q, b3_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     found_q;
	logic [PROD_W-1:0]        p_int_q;
	logic [THIRD_P-1:0]       p_third_q;
	logic [PROD_W:0]          chi_sum;
	logic signed [STRIP_W:0]  diff;
	logic [STRIP_W-1:0]       adiff;
	logic [LUT_W-1:0]         lut_val;
	logic                     out_free;

	assign pl1 = pop_data[0*PLANE_STRIPS +: PLANE_STRIPS];
	assign pl2 = pop_data[1*PLANE_STRIPS +: PLANE_STRIPS];
	assign pl3 = pop_data[2*PLANE_STRIPS +: PLANE_STRIPS];

	always_comb begin
		w1 = '0;
		w2 = '0;
		w3 = '0;
		w1[PLANE_STRIPS-1:0] = rem1_q;
		w2[PLANE_STRIPS-1:0] = rem2_q;
		w3[PLANE_STRIPS-1:0] = rem3_q;
	end

	assign c1     = first_set(w1);
	assign c2     = first_set(w2);
	assign c3     = first_set(w3);
	assign s      = $signed({2'b00, c1}) - $signed({1'b0, c2, 1'b0}) + $signed({2'b00, c3});
	assign mag    = s[STRIP_W+1] ? (STRIP_W+1)'(0) - s[STRIP_W:0] : s[STRIP_W:0];
	assign sq     = RESID_W'(mag) * RESID_W'(mag);
	assign rem1_n = rem1_q & (rem1_q - PLANE_STRIPS'(1));
	assign rem2_n = rem2_q & (rem2_q - PLANE_STRIPS'(1));
	assign rem3_n = rem3_q & (rem3_q - PLANE_STRIPS'(1));

	assign chi_sum  = (PROD_W+1)'(p_int_q) + (PROD_W+1)'(p_third_q >> THIRD_SHIFT);
	assign diff     = $signed({1'b0, b1_q}) - $signed({1'b0, b3_q});
	assign adiff    = diff[STRIP_W] ? STRIP_W'(-diff) : diff[STRIP_W-1:0];
	assign lut_val  = ANGLE_LUT[adiff];
	assign out_free = !out_valid || !out_stall;
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			out_valid         <= 1'b0;
			rem1_q            <= '0;
			rem2_q            <= '0;
			rem3_q            <= '0;
			full2_q           <= '0;
			full3_q           <= '0;
			best_q            <= RESID_INIT;
			b1_q              <= '0;
			b2_q              <= '0;
			b3_q              <= '0;
			count_q           <= '0;
			found_q           <= 1'b0;
			p_int_q           <= '0;
			p_third_q         <= '0;
			fit_found         <= 1'b0;
			best_strip_first  <= '0;
			best_strip_second <= '0;
			best_strip_third  <= '0;
			chi_square_q8     <= '0;
			track_count       <= '0;
			angle_q8          <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_FIN) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						rem1_q  <= pl1;
						rem2_q  <= pl2;
						rem3_q  <= pl3;
						full2_q <= pl2;
						full3_q <= pl3;
						best_q  <= RESID_INIT;
						b1_q    <= '0;
						b2_q    <= '0;
						b3_q    <= '0;
						count_q <= '0;
						found_q <= (pl1 != '0) && (pl2 != '0) && (pl3 != '0);
						state_q <= ((pl1 != '0) && (pl2 != '0) && (pl3 != '0)) ?
							ST_SCAN : ST_CHI;
					end
				end
				ST_SCAN: begin
					if (count_q != COUNT_MAX) begin
						count_q <= count_q + COUNT_W'(1);
					end
					if (sq < best_q) begin
						best_q <= sq;
						b1_q   <= c1;
						b2_q   <= c2;
						b3_q   <= c3;
					end
					if (rem3_n != '0) begin
						rem3_q <= rem3_n;
					end else begin
						rem3_q <= full3_q;
						if (rem2_n != '0) begin
							rem2_q <= rem2_n;
						end else begin
							rem2_q <= full2_q;
							rem1_q <= rem1_n;
							if (rem1_n == '0) begin
								state_q <= ST_CHI;
							end
						end
					end
				end
				ST_CHI: begin
					p_int_q   <= PROD_W'(best_q) * PROD_W'(CHI_INT_MUL);
					p_third_q <= THIRD_P'({1'b0, best_q, 1'b0}) * THIRD_P'(THIRD_MUL);
					state_q   <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid         <= 1'b1;
						fit_found         <= found_q;
						best_strip_first  <= found_q ? b1_q : '0;
						best_strip_second <= found_q ? b2_q : '0;
						best_strip_third  <= found_q ? b3_q : '0;
						track_count       <= found_q ? count_q : '0;
						if (!found_q) begin
							chi_square_q8 <= '0;
							angle_q8      <= '0;
						end else begin
							chi_square_q8 <= (chi_sum > (PROD_W+1)'(CHI_MAX)) ?
								CHI_MAX : chi_sum[CHI_W-1:0];
							angle_q8 <= diff[STRIP_W] ? ANGLE_W'(0) - ANGLE_W'(lut_val)
								: ANGLE_W'(lut_val);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/three_plane_track_fit_unit.sv
// Three-plane track fit unit, top level.
// Hit words: one word per cycle while the event queue has room (two events deep).
// Result word: once the end-of-event word is accepted, the triple search walks
// all n1*n2*n3 triples; n1..n3 are the plane hit counts, one triple per cycle.
// Events without hits in all planes skip the triple search.
// Reset clears the hit bitmaps, the queue and all control state.
`default_nettype none
module three_plane_track_fit_unit #(
	parameter int NUM_MODULES       = tpf_pkg::NUM_MODULES_DEF,
	parameter int STRIPS_PER_MODULE = tpf_pkg::STRIPS_PER_MODULE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      module_index,
	input  wire logic [1:0]                      plane_index,
	input  wire logic [tpf_pkg::WORD_W-1:0]      hit_bits,
	input  wire logic                            end_of_event,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 fit_found,
	output logic [tpf_pkg::STRIP_W-1:0]          best_strip_first,
	output logic [tpf_pkg::STRIP_W-1:0]          best_strip_second,
	output logic [tpf_pkg::STRIP_W-1:0]          best_strip_third,
	output logic [tpf_pkg::CHI_W-1:0]            chi_square_q8,
	output logic [tpf_pkg::COUNT_W-1:0]          track_count,
	output logic signed [tpf_pkg::ANGLE_W-1:0]   angle_q8
);
	import tpf_pkg::*;

	localparam int PLANE_STRIPS = NUM_MODULES * STRIPS_PER_MODULE;
	localparam int DATA_W       = PLANE_COUNT * PLANE_STRIPS;

	q_stat_t           q_stat;
	logic              push;
	logic              pop;
	logic [DATA_W-1:0] push_data;
	logic [DATA_W-1:0] pop_data;

	tpf_front #(
		.NUM_MODULES       (NUM_MODULES),
		.STRIPS_PER_MODULE (STRIPS_PER_MODULE),
		.PLANE_STRIPS      (PLANE_STRIPS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.module_index (module_index),
		.plane_index  (plane_index),
		.hit_bits     (hit_bits),
		.end_of_event (end_of_event),
		.q_stat       (q_stat),
		.push         (push),
		.push_data    (push_data)
	);

	tpf_queue #(
		.DATA_W (DATA_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	tpf_back #(
		.PLANE_STRIPS (PLANE_STRIPS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_stat            (q_stat),
		.pop_data          (pop_data),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.fit_found         (fit_found),
		.best_strip_first  (best_strip_first),
		.best_strip_second (best_strip_second),
		.best_strip_third  (best_strip_third),
		.chi_square_q8     (chi_square_q8),
		.track_count       (track_count),
		.angle_q8          (angle_q8)
	);
endmodule
`default_nettype wire

FILE: src/tpf_checker.sv
// Port-level checker for the track fit unit, bound to the top level.
`default_nettype none
`include "three_plane_track_fit_unit_assert.svh"
module tpf_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic                          fit_found,
	input wire logic [tpf_pkg::STRIP_W-1:0]   best_strip_first,
	input wire logic [tpf_pkg::STRIP_W-1:0]   best_strip_second,
	input wire logic [tpf_pkg::STRIP_W-1:0]   best_strip_third,
	input wire logic [tpf_pkg::CHI_W-1:0]     chi_square_q8,
	input wire logic [tpf_pkg::COUNT_W-1:0]   track_count,
	input wire logic [tpf_pkg::ANGLE_W-1:0]   angle_q8
);
	logic all_zero;
	logic flat;

	assign all_zero = best_strip_first == '0 && best_strip_second == '0
		&& best_strip_third == '0 && chi_square_q8 == '0 && track_count == '0
		&& angle_q8 == '0;
	assign flat = best_strip_first == best_strip_third;

	`TPF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped")
	`TPF_ASSERT_NOW(a_nofit_zero, out_valid && !fit_found, all_zero, "no-fit word not zero")
	`TPF_ASSERT_NOW(a_fit_count, out_valid && fit_found, track_count != '0, "fit with no triples")
	`TPF_ASSERT_NOW(a_flat_angle, out_valid && flat, angle_q8 == '0, "angle nonzero, flat track")
endmodule

bind three_plane_track_fit_unit tpf_checker u_tpf_checker (.*);
`default_nettype wire
